[rtl/wav_pcm16_stream_parser_assert.svh]
// assertion macros for the bound checker module
`ifndef WAV_PCM16_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM16_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define WPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wps assertion failed");

// next-cycle implication, off during reset
`define WPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wps assertion failed");

// next-cycle implication that also holds across reset
`define WPS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wps assertion failed");

`endif

[rtl/wps_pkg.sv]
package wps_pkg;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int RATE_W   = 32;
  localparam int COUNT_W  = 31;
  localparam int POS_W    = 6;
  localparam int HALF_W   = 16;

  localparam int WPS_OUT_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } wps_phase_t;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IO     = 2'd3;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  localparam logic [RATE_W-1:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [HALF_W-1:0] FMT_PCM        = 16'd1;
  localparam logic [HALF_W-1:0] MONO           = 16'd1;
  localparam logic [HALF_W-1:0] ALIGN_16BIT    = 16'd2;
  localparam logic [HALF_W-1:0] BITS_16        = 16'd16;

  // last byte of each checked or captured little-endian header field
  localparam logic [POS_W-1:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [POS_W-1:0] POS_FORMAT    = 6'd21;
  localparam logic [POS_W-1:0] POS_CHANNELS  = 6'd23;
  localparam logic [POS_W-1:0] POS_RATE      = 6'd27;
  localparam logic [POS_W-1:0] POS_ALIGN     = 6'd33;
  localparam logic [POS_W-1:0] POS_BITS      = 6'd35;
  localparam logic [POS_W-1:0] POS_DATA_SIZE = 6'd43;

  typedef struct packed {
    logic                       hit;
    logic [BYTE_W-1:0]          want;
  } wps_tag_check_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       done_res;
    logic [STATUS_W-1:0]        status;
    logic [RATE_W-1:0]          sample_rate;
    logic [COUNT_W-1:0]         sample_total;
  } wps_result_t;

  // tag text holds its first character in the top byte
  function automatic logic [BYTE_W-1:0] tag_byte(input logic [31:0] tag,
                                                 input logic [1:0] idx);
    logic [1:0] sel;
    sel = 2'd3 - idx;
    return tag[{sel, 3'b000} +: BYTE_W];
  endfunction

  function automatic wps_tag_check_t tag_expect(input logic [POS_W-1:0] pos);
    wps_tag_check_t chk;
    chk.hit  = 1'b1;
    chk.want = '0;
    case (pos) inside
      [6'd0:6'd3]:   chk.want = tag_byte(TAG_RIFF, pos[1:0]);
      [6'd8:6'd11]:  chk.want = tag_byte(TAG_WAVE, pos[1:0]);
      [6'd12:6'd15]: chk.want = tag_byte(TAG_FMT, pos[1:0]);
      [6'd36:6'd39]: chk.want = tag_byte(TAG_DATA, pos[1:0]);
      default:       chk.hit = 1'b0;
    endcase
    return chk;
  endfunction

endpackage

[rtl/wps_if.sv]
interface wps_byte_if import wps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_file;
  logic              stream_end;

  modport source(output valid, data_byte, start_of_file, stream_end, input ready);
  modport sink(input valid, data_byte, start_of_file, stream_end, output ready);
endinterface

interface wps_result_if import wps_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_valid;
  logic                       done_res;
  logic [STATUS_W-1:0]        status;
  logic [RATE_W-1:0]          sample_rate;
  logic [COUNT_W-1:0]         sample_total;

  modport source(output valid, sample, sample_valid, done_res, status, sample_rate,
                 sample_total, input ready);
  modport sink(input valid, sample, sample_valid, done_res, status, sample_rate,
               sample_total, output ready);
endinterface

interface wps_cfg_if import wps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] capacity;

  modport source(output valid, capacity, input ready);
  modport sink(input valid, capacity, output ready);
endinterface

[rtl/wps_parse_core.sv]
module wps_parse_core import wps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               start_of_file,
  input  logic               stream_end,
  input  logic [COUNT_W-1:0] capacity,
  output logic               push,
  output wps_result_t        result
);

  wps_phase_t          phase, phase_next, phase_c;
  logic [POS_W-1:0]    byte_position, pos_next, pos_c;
  logic [RATE_W-1:0]   field_shift, fs_next, fs_c, fs_hdr;
  logic [HALF_W-1:0]   audio_format, fmt_next, fmt_c;
  logic [HALF_W-1:0]   channel_count, chan_next, chan_c;
  logic [HALF_W-1:0]   block_alignment, align_next, align_c;
  logic [HALF_W-1:0]   sample_bits, bits_next, bits_c;
  logic [RATE_W-1:0]   rate_held, rate_next, rate_c;
  logic [COUNT_W-1:0]  samples_left, left_next, left_c, left_dec;
  logic [COUNT_W-1:0]  total_held, total_next, total_c, count;
  logic [BYTE_W-1:0]   low_byte, low_next, low_c;
  logic                odd_byte, odd_next, odd_c;
  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  wps_tag_check_t      chk;

  always_comb begin
    // a start flag clears the parse before this byte is looked at
    phase_c = start_of_file ? PH_HEADER : phase;
    pos_c   = start_of_file ? '0 : byte_position;
    fs_c    = start_of_file ? '0 : field_shift;
    fmt_c   = start_of_file ? '0 : audio_format;
    chan_c  = start_of_file ? '0 : channel_count;
    align_c = start_of_file ? '0 : block_alignment;
    bits_c  = start_of_file ? '0 : sample_bits;
    rate_c  = start_of_file ? '0 : rate_held;
    left_c  = start_of_file ? '0 : samples_left;
    total_c = start_of_file ? '0 : total_held;
    low_c   = start_of_file ? '0 : low_byte;
    odd_c   = start_of_file ? 1'b0 : odd_byte;

    phase_next = phase_c;
    pos_next   = pos_c;
    fs_next    = fs_c;
    fmt_next   = fmt_c;
    chan_next  = chan_c;
    align_next = align_c;
    bits_next  = bits_c;
    rate_next  = rate_c;
    left_next  = left_c;
    total_next = total_c;
    low_next   = low_c;
    odd_next   = odd_c;

    fs_hdr   = {data_byte, fs_c[RATE_W-1:BYTE_W]};
    count    = fs_hdr[RATE_W-1:1];
    chk      = tag_expect(pos_c);
    left_dec = left_c - 1'b1;

    fin        = 1'b0;
    fin_status = ST_OK;
    push       = 1'b0;
    result.sample       = '0;
    result.sample_valid = 1'b0;
    result.done_res     = 1'b0;
    result.status       = ST_OK;

    unique case (phase_c)
      PH_HEADER: begin
        if (stream_end) begin
          fin        = 1'b1;
          fin_status = ST_FORMAT;
        end else begin
          fs_next = fs_hdr;
          if (chk.hit && (data_byte != chk.want)) begin
            fin        = 1'b1;
            fin_status = ST_FORMAT;
          end else begin
            pos_next = pos_c + 1'b1;
            case (pos_c)
              POS_FMT_SIZE: begin
                if (fs_hdr != FMT_CHUNK_SIZE) begin
                  fin        = 1'b1;
                  fin_status = ST_FORMAT;
                end
              end
              POS_FORMAT:   fmt_next   = fs_hdr[RATE_W-1:HALF_W];
              POS_CHANNELS: chan_next  = fs_hdr[RATE_W-1:HALF_W];
              POS_RATE:     rate_next  = fs_hdr;
              POS_ALIGN:    align_next = fs_hdr[RATE_W-1:HALF_W];
              POS_BITS:     bits_next  = fs_hdr[RATE_W-1:HALF_W];
              POS_DATA_SIZE: begin
                if ((fmt_c != FMT_PCM) || (chan_c != MONO) || (align_c != ALIGN_16BIT) ||
                    (bits_c != BITS_16) || fs_hdr[0]) begin
                  fin        = 1'b1;
                  fin_status = ST_FORMAT;
                end else begin
                  total_next = count;
                  if (count > capacity) begin
                    fin        = 1'b1;
                    fin_status = ST_SMALL;
                  end else if (count == '0) begin
                    fin        = 1'b1;
                    fin_status = ST_OK;
                  end else begin
                    phase_next = PH_DATA;
                    left_next  = count;
                    odd_next   = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      PH_DATA: begin
        if (stream_end) begin
          fin        = 1'b1;
          fin_status = ST_IO;
        end else if (!odd_c) begin
          low_next = data_byte;
          odd_next = 1'b1;
        end else begin
          odd_next            = 1'b0;
          left_next           = left_dec;
          push                = 1'b1;
          result.sample_valid = 1'b1;
          result.sample       = $signed({data_byte, low_c});
          if (left_dec == '0) begin
            phase_next      = PH_DONE;
            result.done_res = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (fin) begin
      phase_next      = PH_DONE;
      push            = 1'b1;
      result.done_res = 1'b1;
      result.status   = fin_status;
    end

    push                = push && step;
    result.sample_rate  = rate_next;
    result.sample_total = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      field_shift     <= '0;
      audio_format    <= '0;
      channel_count   <= '0;
      block_alignment <= '0;
      sample_bits     <= '0;
      rate_held       <= '0;
      samples_left    <= '0;
      total_held      <= '0;
      low_byte        <= '0;
      odd_byte        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_position   <= pos_next;
      field_shift     <= fs_next;
      audio_format    <= fmt_next;
      channel_count   <= chan_next;
      block_alignment <= align_next;
      sample_bits     <= bits_next;
      rate_held       <= rate_next;
      samples_left    <= left_next;
      total_held      <= total_next;
      low_byte        <= low_next;
      odd_byte        <= odd_next;
    end
  end

endmodule

[rtl/wps_out_queue.sv]
module wps_out_queue import wps_pkg::*; #(
  parameter int DEPTH = WPS_OUT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  wps_result_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        valid,
  output wps_result_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  wps_result_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign valid  = (count != '0);
  assign full   = (count == CNT_W'(DEPTH));
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/wav_pcm16_stream_parser.sv]
// path: a taken byte waits in the input register, and any result it makes is written to the result queue
// throughput: one byte per cycle, set by the single-pass parse between the
//   input register and the result queue; stalls only when the queue is full
// reset: synchronous, active high; parse returns to header byte 0, capacity
//   goes to 0x7fffffff, input register and result queue empty
module wav_pcm16_stream_parser import wps_pkg::*; #(
  parameter int OUT_DEPTH = WPS_OUT_DEPTH
) (
  input logic           clk,
  input logic           rst,
  wps_byte_if.sink      byte_stream,
  wps_result_if.source  samples,
  wps_cfg_if.sink       cfg
);

  // capacity register; the user must write it only while the block is idle, the block does not enforce this
  logic [COUNT_W-1:0] capacity;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_sof;
  logic              in_end;

  // core to queue
  logic        step;
  logic        push;
  logic        q_full;
  logic        q_valid;
  wps_result_t push_data;
  wps_result_t head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg.valid) begin
      capacity <= cfg.capacity;
    end
  end

  // the held byte moves into the parser whenever the result queue has room
  assign step              = in_valid && !q_full;
  assign byte_stream.ready = !in_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      in_byte <= byte_stream.data_byte;
      in_sof  <= byte_stream.start_of_file;
      in_end  <= byte_stream.stream_end;
    end
  end

  // header tags, field capture, format checks and sample assembly
  wps_parse_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .start_of_file (in_sof),
    .stream_end    (in_end),
    .capacity      (capacity),
    .push          (push),
    .result        (push_data)
  );

  // result queue with skid room, so a byte can be taken while a result waits
  wps_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (samples.ready),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head)
  );

  // one transaction per queued result
  assign samples.valid        = q_valid;
  assign samples.sample       = head.sample;
  assign samples.sample_valid = head.sample_valid;
  assign samples.done_res     = head.done_res;
  assign samples.status       = head.status;
  assign samples.sample_rate  = head.sample_rate;
  assign samples.sample_total = head.sample_total;

endmodule

[rtl/wps_checker.sv]
`include "wav_pcm16_stream_parser_assert.svh"

module wps_checker import wps_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       sample_valid,
  input logic                       done_res,
  input logic [STATUS_W-1:0]        status,
  input logic [COUNT_W-1:0]         sample_total
);

  // a stalled result keeps its contents
  `WPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample) && $stable(status) && $stable(done_res))

  // back pressure on the input only comes from a pending result
  `WPS_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid)

  // nothing is offered right after reset
  `WPS_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // a clean end without a sample only comes from an empty data chunk
  `WPS_ASSERT_NOW(a_empty_ok, clk, rst, out_valid && done_res && !sample_valid && (status == ST_OK), sample_total == '0)

  // error codes travel only on the last result of a file
  `WPS_ASSERT_NOW(a_status_done, clk, rst, out_valid && (status != ST_OK), done_res && !sample_valid)

endmodule

bind wav_pcm16_stream_parser wps_checker u_wps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (byte_stream.ready),
  .out_valid    (samples.valid),
  .out_ready    (samples.ready),
  .sample       (samples.sample),
  .sample_valid (samples.sample_valid),
  .done_res     (samples.done_res),
  .status       (samples.status),
  .sample_total (samples.sample_total)
);

[dv/wps_parse_checker.sv]
module wps_parse_checker import wps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  wps_byte_if   byte_stream,
  wps_result_if samples,
  wps_cfg_if    cfg,
  output int    mismatches,
  output int    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as seen from the byte stream
  logic [COUNT_W-1:0] cap_limit;
  logic [POS_W-1:0]   hdr_pos;
  wps_phase_t         phase;
  logic [31:0]        shift_reg;
  logic [HALF_W-1:0]  fmt_code;
  logic [HALF_W-1:0]  chan_num;
  logic [HALF_W-1:0]  align_val;
  logic [HALF_W-1:0]  bit_depth;
  logic [RATE_W-1:0]  rate_val;
  logic [COUNT_W-1:0] left_cnt;
  logic [COUNT_W-1:0] total_cnt;
  logic [BYTE_W-1:0]  lo_byte;
  logic               odd_half;

  // decoded results still to come out of the block, oldest first
  wps_result_t decoded_q[$];

  function automatic bit tag_want(input logic [POS_W-1:0] pos, output logic [7:0] want);
    logic [31:0] tag;
    want = '0;
    if (pos < 6'd4) tag = TAG_RIFF;
    else if (pos >= 6'd8 && pos < 6'd12) tag = TAG_WAVE;
    else if (pos >= 6'd12 && pos < 6'd16) tag = TAG_FMT;
    else if (pos >= 6'd36 && pos < 6'd40) tag = TAG_DATA;
    else return 1'b0;
    // first character sits in the top byte
    want = tag[8 * (3 - pos[1:0]) +: 8];
    return 1'b1;
  endfunction

  function void restart_parse();
    hdr_pos   = '0;
    phase     = PH_HEADER;
    shift_reg = '0;
    fmt_code  = '0;
    chan_num  = '0;
    align_val = '0;
    bit_depth = '0;
    rate_val  = '0;
    left_cnt  = '0;
    total_cnt = '0;
    lo_byte   = '0;
    odd_half  = 1'b0;
  endfunction

  function void push_result(logic [15:0] smp, logic vld, logic done, logic [1:0] st);
    wps_result_t r;
    r.sample       = smp;
    r.sample_valid = vld;
    r.done_res     = done;
    r.status       = st;
    r.sample_rate  = rate_val;
    r.sample_total = total_cnt;
    decoded_q.push_back(r);
  endfunction

  function void close_file(logic [1:0] st);
    phase = PH_DONE;
    push_result('0, 1'b0, 1'b1, st);
  endfunction

  function void parse_header(logic [7:0] b);
    logic [7:0]       want;
    logic [POS_W-1:0] p;
    bit               hit;
    p = hdr_pos;
    shift_reg = {b, shift_reg[31:8]};
    hit = tag_want(p, want);
    if (hit && b != want) begin
      close_file(ST_FORMAT);
      return;
    end
    hdr_pos = p + 1'b1;
    case (p)
      POS_FMT_SIZE: if (shift_reg != FMT_CHUNK_SIZE) close_file(ST_FORMAT);
      POS_FORMAT:   fmt_code = shift_reg[31:16];
      POS_CHANNELS: chan_num = shift_reg[31:16];
      POS_RATE:     rate_val = shift_reg;
      POS_ALIGN:    align_val = shift_reg[31:16];
      POS_BITS:     bit_depth = shift_reg[31:16];
      POS_DATA_SIZE: begin
        if (fmt_code != FMT_PCM || chan_num != MONO || align_val != ALIGN_16BIT ||
            bit_depth != BITS_16 || shift_reg[0]) begin
          close_file(ST_FORMAT);
        end else begin
          total_cnt = shift_reg[31:1];
          if (total_cnt > cap_limit) close_file(ST_SMALL);
          else if (total_cnt == '0) close_file(ST_OK);
          else begin
            phase    = PH_DATA;
            left_cnt = total_cnt;
            odd_half = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void parse_sample(logic [7:0] b);
    if (!odd_half) begin
      lo_byte  = b;
      odd_half = 1'b1;
    end else begin
      odd_half = 1'b0;
      left_cnt = left_cnt - 1'b1;
      if (left_cnt == '0) begin
        phase = PH_DONE;
        push_result({b, lo_byte}, 1'b1, 1'b1, ST_OK);
      end else begin
        push_result({b, lo_byte}, 1'b1, 1'b0, ST_OK);
      end
    end
  endfunction

  function void parse_wav_byte(logic [7:0] b, logic sof, logic eos);
    if (sof) restart_parse();
    case (phase)
      PH_HEADER: if (eos) close_file(ST_FORMAT); else parse_header(b);
      PH_DATA:   if (eos) close_file(ST_IO); else parse_sample(b);
      default: ;
    endcase
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    wps_result_t due;
    if (rst) begin
      cap_limit = '1;
      restart_parse();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      // results first: a byte taken at this edge cannot have its result out yet
      if (samples.valid && samples.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result transaction with nothing pending: sample 0x%0h done %0b status %0d",
                 samples.sample, samples.done_res, samples.status);
          mismatches++;
        end else begin
          due = decoded_q.pop_front();
          check_field("sample", 32'(due.sample), 32'(samples.sample));
          check_field("sample_valid", 32'(due.sample_valid), 32'(samples.sample_valid));
          check_field("done_res", 32'(due.done_res), 32'(samples.done_res));
          check_field("status", 32'(due.status), 32'(samples.status));
          check_field("sample_rate", due.sample_rate, samples.sample_rate);
          check_field("sample_total", 32'(due.sample_total), 32'(samples.sample_total));
        end
      end
      if (byte_stream.valid && byte_stream.ready)
        parse_wav_byte(byte_stream.data_byte, byte_stream.start_of_file,
                       byte_stream.stream_end);
      if (cfg.valid && cfg.ready) cap_limit = cfg.capacity;
    end
    awaiting <= decoded_q.size();
  end

endmodule

[dv/wav_pcm16_stream_parser_tb.sv]
module wav_pcm16_stream_parser_tb import wps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1000;
  // far above the slowest legal run
  localparam int CYCLE_LIMIT  = 400000;
  // quiet cycles after the last result, so a byte left in the input register drains
  localparam int SETTLE       = 8;
  // sample extremes, little-endian: 0x8000, 0x7fff, 0x0000, 0xffff
  localparam logic [63:0] EDGE_SAMPLES = 64'hFFFF_0000_7FFF_8000;

  typedef struct {
    logic [31:0] rate;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] fmt_len;
    logic [31:0] payload_len;
  } wav_header_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;       // no idling on either side while set
  int   bytes_sent = 0;
  int   cycle_count = 0;
  int   mismatches;
  int   awaiting;

  wps_byte_if   byte_stream ();
  wps_result_if samples ();
  wps_cfg_if    cfg ();

  wav_pcm16_stream_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .samples     (samples),
    .cfg         (cfg)
  );

  wps_parse_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .samples     (samples),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .awaiting    (awaiting)
  );

  always #5 clk = ~clk;

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side backpressure, about one stall cycle in three
  always @(posedge clk) begin
    if (rst) samples.ready <= 1'b0;
    else samples.ready <= calm || ($urandom_range(99) >= 35);
  end

  // canonical mono 16-bit pcm header
  function automatic wav_header_t pcm_mono(logic [31:0] rate, logic [31:0] size);
    wav_header_t h;
    h.rate        = rate;
    h.fmt_code    = FMT_PCM;
    h.chans       = MONO;
    h.align       = ALIGN_16BIT;
    h.bits        = BITS_16;
    h.fmt_len     = FMT_CHUNK_SIZE;
    h.payload_len = size;
    return h;
  endfunction

  // data size in bytes: mostly short files, now and then a full 32-bit count
  function automatic logic [31:0] pick_size();
    logic [31:0] size;
    case ($urandom_range(9))
      7: begin
        size = $urandom;
        size[0] = 1'b0;
      end
      8, 9: size = 2 * $urandom_range(25, 60);
      default: size = 2 * $urandom_range(0, 24);
    endcase
    return size;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_capacity();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return COUNT_W'($urandom_range(0, 40));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  // one byte transaction, with random idle cycles ahead of it unless calm is set
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eos);
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        byte_stream.valid <= 1'b0;
        @(posedge clk);
      end
    end
    byte_stream.valid         <= 1'b1;
    byte_stream.data_byte     <= b;
    byte_stream.start_of_file <= sof;
    byte_stream.stream_end    <= eos;
    @(posedge clk);
    while (!byte_stream.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // header bytes 0..43; bad_pos gets flip xored in, cut_pos ends the stream there
  task automatic send_header(input wav_header_t h, input int bad_pos, input logic [7:0] flip,
                             input int cut_pos);
    logic [7:0]  hdr [44];
    logic [31:0] riff_len;
    logic [31:0] byte_rate;
    riff_len  = h.payload_len + 32'd36;
    byte_rate = h.rate << 1;
    for (int k = 0; k < 4; k++) begin
      hdr[k]      = TAG_RIFF[31 - 8 * k -: 8];
      hdr[4 + k]  = riff_len[8 * k +: 8];
      hdr[8 + k]  = TAG_WAVE[31 - 8 * k -: 8];
      hdr[12 + k] = TAG_FMT[31 - 8 * k -: 8];
      hdr[16 + k] = h.fmt_len[8 * k +: 8];
      hdr[24 + k] = h.rate[8 * k +: 8];
      hdr[28 + k] = byte_rate[8 * k +: 8];
      hdr[36 + k] = TAG_DATA[31 - 8 * k -: 8];
      hdr[40 + k] = h.payload_len[8 * k +: 8];
    end
    for (int k = 0; k < 2; k++) begin
      hdr[20 + k] = h.fmt_code[8 * k +: 8];
      hdr[22 + k] = h.chans[8 * k +: 8];
      hdr[32 + k] = h.align[8 * k +: 8];
      hdr[34 + k] = h.bits[8 * k +: 8];
    end
    if (bad_pos >= 0 && bad_pos < 44) hdr[bad_pos] = hdr[bad_pos] ^ flip;
    for (int p = 0; p < 44; p++) begin
      if (p == cut_pos) begin
        send_byte(8'($urandom), p == 0, 1'b1);
        return;
      end
      send_byte(hdr[p], p == 0, 1'b0);
    end
  endtask

  task automatic send_data(input logic [31:0] n);
    for (logic [31:0] i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // hold the sender until every predicted result is out, then let the pipe drain
  task automatic quiesce();
    byte_stream.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] v);
    quiesce();
    cfg.valid    <= 1'b1;
    cfg.capacity <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    wav_header_t h;
    int          kind;
    int          start;
    int          files;
    int          bad_pos;
    int          cut_pos;
    logic [7:0]  flip;
    logic [31:0] n;

    byte_stream.valid         = 1'b0;
    byte_stream.data_byte     = '0;
    byte_stream.start_of_file = 1'b0;
    byte_stream.stream_end    = 1'b0;
    cfg.valid                 = 1'b0;
    cfg.capacity              = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---------------- directed cases ----------------
    write_capacity('1);

    // good file, highest rate, the four sample extremes, last one carries done
    send_header(pcm_mono(32'hFFFF_FFFF, 32'd8), -1, 8'h00, -1);
    for (int i = 0; i < 8; i++) send_byte(EDGE_SAMPLES[8 * i +: 8], 1'b0, 1'b0);

    // zero-length data closes ok at the last header byte
    send_header(pcm_mono(32'd0, 32'd0), -1, 8'h00, -1);

    // tag mismatch on each of the four tags, flagged on the differing byte
    send_header(pcm_mono(32'd8000, 32'd4), 0, 8'h01, -1);
    send_header(pcm_mono(32'd8000, 32'd4), 9, 8'h80, -1);
    send_header(pcm_mono(32'd8000, 32'd4), 15, 8'hFF, -1);
    send_header(pcm_mono(32'd8000, 32'd4), 38, 8'h20, -1);

    // fmt chunk size other than 16
    h = pcm_mono(32'd22050, 32'd4);
    h.fmt_len = 32'd18;
    send_header(h, -1, 8'h00, -1);

    // each format field wrong in turn, then an odd data size
    for (int f = 0; f < 5; f++) begin
      h = pcm_mono(32'd48000, 32'd4);
      case (f)
        0: h.fmt_code = 16'd3;
        1: h.chans = 16'd2;
        2: h.align = 16'd4;
        3: h.bits = 16'd8;
        default: h.payload_len = 32'd5;
      endcase
      send_header(h, -1, 8'h00, -1);
    end

    // end of stream inside the header, and together with start of file
    send_header(pcm_mono(32'd11025, 32'd4), -1, 8'h00, 20);
    send_header(pcm_mono(32'd11025, 32'd4), -1, 8'h00, 0);

    // end of stream inside the data, then bytes after done are dropped
    send_header(pcm_mono(32'd44100, 32'd20), -1, 8'h00, -1);
    send_data(32'd6);
    send_end();
    send_byte(8'h5A, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);

    // restart in the middle of the data
    send_header(pcm_mono(32'd8000, 32'd10), -1, 8'h00, -1);
    send_data(32'd3);
    send_header(pcm_mono(32'd16000, 32'd4), -1, 8'h00, -1);
    send_data(32'd4);

    // capacity boundary: count equal passes, one more is too small
    write_capacity(COUNT_W'(3));
    send_header(pcm_mono(32'd32000, 32'd6), -1, 8'h00, -1);
    send_data(32'd6);
    send_header(pcm_mono(32'd32000, 32'd8), -1, 8'h00, -1);

    // zero capacity only takes an empty file
    write_capacity('0);
    send_header(pcm_mono(32'd96000, 32'd2), -1, 8'h00, -1);
    send_header(pcm_mono(32'd96000, 32'd0), -1, 8'h00, -1);

    // largest count at full capacity, cut short by end of stream
    write_capacity('1);
    send_header(pcm_mono(32'h1234_5678, 32'hFFFF_FFFE), -1, 8'h00, -1);
    send_data(32'd4);
    send_end();

    // ---------------- random files ----------------
    start = bytes_sent;
    files = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // one long stretch with both sides running flat out
      calm <= (files >= 8 && files < 14);
      if (files % 9 == 8) write_capacity(pick_capacity());
      kind = $urandom_range(99);
      h = pcm_mono($urandom, pick_size());
      if (kind < 65) begin
        // well-formed file, random content
        send_header(h, -1, 8'h00, -1);
        if (h.payload_len <= 32'd200) begin
          case ($urandom_range(7))
            0: begin
              send_data($urandom_range(0, h.payload_len));
              send_end();
            end
            1: send_data($urandom_range(0, h.payload_len));   // next file restarts
            default: send_data(h.payload_len);
          endcase
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
          end
        end else begin
          send_data($urandom_range(0, 16));
          send_end();
        end
      end else if (kind < 90) begin
        // broken header of one kind or another
        bad_pos = -1;
        cut_pos = -1;
        flip    = 8'h00;
        case ($urandom_range(4))
          0: begin
            case ($urandom_range(3))
              0: bad_pos = 0;
              1: bad_pos = 8;
              2: bad_pos = 12;
              default: bad_pos = 36;
            endcase
            bad_pos = bad_pos + $urandom_range(3);
            flip = 8'($urandom_range(1, 255));
          end
          1: begin
            bad_pos = $urandom_range(43);
            flip = 8'($urandom_range(1, 255));
          end
          2: cut_pos = $urandom_range(43);
          3: h.payload_len[0] = 1'b1;
          default: begin
            case ($urandom_range(4))
              0: h.fmt_len = $urandom_range(0, 40);
              1: h.fmt_code = 16'($urandom_range(0, 3));
              2: h.chans = 16'($urandom_range(0, 2));
              3: h.align = 16'($urandom_range(0, 4));
              default: h.bits = 16'($urandom_range(8, 24));
            endcase
          end
        endcase
        send_header(h, bad_pos, flip, cut_pos);
        send_data($urandom_range(0, 6));
        if ($urandom_range(1) == 1) send_end();
      end else begin
        // loose noise with stray start and end flags
        n = $urandom_range(1, 16);
        repeat (n) begin
          send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
        end
      end
      files++;
    end

    // drain everything, then give the verdict
    quiesce();
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
